// File: rtl/bsls_pkg.sv
// Shared types, character codes and helpers for the bracket string literal scanner.
// Used by the level cells, the level stack, the result queue and the top level.
package bsls_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_ESC   = 8'h5C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       bad;
  } res_t;

  // Commands from the scanner control to the chain of level cells.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic wr_en;
    logic wr_val;
  } stk_ctl_t;

  // Status of the level stack as seen by the scanner control.
  typedef struct packed {
    logic empty;
    logic one_level;
    logic full;
    logic top_code;
  } stk_stat_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// File: rtl/bracket_string_literal_scanner.sv
// Top level of the bracket string literal scanner: scanner control, level stack
// and result queue. Depends on bsls_pkg, bsls_stack and bsls_outq.
//
//   Channel  Direction  Handshake           Payload
//   in       sink       in_valid/in_stall   in_byte, source_ends
//   out      source     out_valid/out_stall out_byte, literal_done, unbalanced
//
// One byte is taken per cycle unless in_stall is high; its results are written
// into the result queue at the same clock edge and can leave in the next cycle.
// A byte gives at most two results (its own and an error), so the input is
// stalled while fewer than two queue entries are free.
// Reset empties the level stack and the queue; there is no clearing pass.
// A stall on the output side backs up into in_stall once three results are waiting.
module bracket_string_literal_scanner #(
  parameter int MAX_NESTING = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       source_ends,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       literal_done,
  output logic       unbalanced
);
  import bsls_pkg::*;

  // Scanner flags: deciding the mode of a freshly opened level, a pending
  // backslash escape, and a comment running to the end of the line.
  logic detecting;
  logic escaping;
  logic commenting;
  logic detecting_next;
  logic escaping_next;
  logic commenting_next;

  logic      accept;
  logic      room;
  stk_ctl_t  ctl;
  stk_ctl_t  ctl_gated;
  stk_stat_t stat;
  res_t      r0;
  res_t      r1;
  res_t      res_out;
  logic      r0_v;
  logic      r1_v;
  logic      live;
  logic      handled;
  logic      code;

  assign in_stall = ~room;
  assign accept   = in_valid & room;

  // The decision for one transaction: what to emit, how the stack moves and
  // how the flags change. Of the stack it looks only at the status flags.
  always_comb begin
    r0              = '0;
    r1              = '0;
    r1.bad          = 1'b1;
    r0_v            = 1'b0;
    r1_v            = 1'b0;
    ctl             = '0;
    detecting_next  = detecting;
    escaping_next   = escaping;
    commenting_next = commenting;
    live            = ~stat.empty;
    handled         = 1'b0;
    code            = 1'b0;
    r0.data         = in_byte;

    if (stat.empty) begin
      // Outside a literal only an opening bracket matters.
      if (in_byte == CH_OPEN) begin
        ctl.push        = 1'b1;
        detecting_next  = 1'b1;
        escaping_next   = 1'b0;
        commenting_next = 1'b0;
        r0_v            = 1'b1;
        live            = 1'b1;
      end
    end else if (escaping) begin
      escaping_next = 1'b0;
      r0_v          = 1'b1;
    end else if (commenting && (in_byte != CH_NL)) begin
      r0_v = 1'b1;
    end else begin
      commenting_next = 1'b0;
      code            = stat.top_code;
      if (detecting) begin
        if (is_blank(in_byte)) begin
          r0_v    = 1'b1;
          handled = 1'b1;
          if (in_byte == CH_NL) begin
            // A newline before anything else makes this a code level.
            ctl.wr_en      = 1'b1;
            ctl.wr_val     = 1'b1;
            detecting_next = 1'b0;
          end
        end else begin
          ctl.wr_en      = 1'b1;
          ctl.wr_val     = 1'b0;
          detecting_next = 1'b0;
          code           = 1'b0;
        end
      end
      if (!handled) begin
        if (in_byte == CH_ESC) begin
          escaping_next = 1'b1;
        end else if ((in_byte == CH_HASH) && code) begin
          r0_v            = 1'b1;
          commenting_next = 1'b1;
        end else if (in_byte == CH_OPEN) begin
          if (stat.full) begin
            // Nesting too deep: error only, back to idle.
            r0              = '0;
            r0.bad          = 1'b1;
            r0_v            = 1'b1;
            ctl.clear       = 1'b1;
            detecting_next  = 1'b0;
            escaping_next   = 1'b0;
            commenting_next = 1'b0;
            live            = 1'b0;
          end else begin
            // Only a code level lets the new level decide its own mode.
            ctl.push       = 1'b1;
            detecting_next = code;
            r0_v           = 1'b1;
          end
        end else if (in_byte == CH_CLOSE) begin
          r0.done = stat.one_level;
          r0_v    = 1'b1;
          ctl.pop = 1'b1;
          if (stat.one_level) begin
            detecting_next  = 1'b0;
            escaping_next   = 1'b0;
            commenting_next = 1'b0;
            live            = 1'b0;
          end
        end else begin
          r0_v = 1'b1;
        end
      end
    end

    // End of source with the literal still open adds an error result.
    if (source_ends && live) begin
      r1_v            = 1'b1;
      ctl.clear       = 1'b1;
      detecting_next  = 1'b0;
      escaping_next   = 1'b0;
      commenting_next = 1'b0;
    end
  end

  assign ctl_gated = accept ? ctl : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      detecting  <= 1'b0;
      escaping   <= 1'b0;
      commenting <= 1'b0;
    end else if (accept) begin
      detecting  <= detecting_next;
      escaping   <= escaping_next;
      commenting <= commenting_next;
    end
  end

  bsls_stack #(
    .MAX_NESTING (MAX_NESTING)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_gated),
    .stat (stat)
  );

  bsls_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push0     (accept & r0_v),
    .res0      (r0),
    .push1     (accept & r1_v),
    .res1      (r1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign out_byte     = res_out.data;
  assign literal_done = res_out.done;
  assign unbalanced   = res_out.bad;

endmodule

// File: rtl/bsls_cell.sv
// One nesting level cell: an occupancy bit and the level's code-mode bit.
// Depends on bsls_pkg for the stack command struct.
module bsls_cell (
  input  logic                clk,
  input  logic                rst,
  input  bsls_pkg::stk_ctl_t  ctl,
  input  logic                wr_en,
  input  logic                wr_val,
  input  logic                occ_up,
  input  logic                mode_up,
  input  logic                occ_down,
  input  logic                mode_down,
  output logic                occ,
  output logic                mode,
  output logic                pass_mode
);
  import bsls_pkg::*;

  logic occ_next;
  logic mode_next;

  // The value handed to the deeper neighbour includes a write made in the same cycle.
  assign pass_mode = wr_en ? wr_val : mode;

  always_comb begin
    if (ctl.clear) begin
      occ_next = 1'b0;
    end else if (ctl.push) begin
      occ_next = occ_up;
    end else if (ctl.pop) begin
      occ_next = occ_down;
    end else begin
      occ_next = occ;
    end
  end

  always_comb begin
    if (ctl.push) begin
      mode_next = mode_up;
    end else if (ctl.pop) begin
      mode_next = mode_down;
    end else begin
      mode_next = pass_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    mode <= mode_next;
  end

endmodule

// File: rtl/bsls_stack.sv
// Row of level cells forming the nesting stack; cell 0 holds the innermost level.
// Depends on bsls_pkg and bsls_cell.
module bsls_stack #(
  parameter int MAX_NESTING = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  bsls_pkg::stk_ctl_t  ctl,
  output bsls_pkg::stk_stat_t stat
);
  import bsls_pkg::*;

  logic [MAX_NESTING:0]   occ_ext;
  logic [MAX_NESTING:0]   mode_ext;
  logic [MAX_NESTING-1:0] pass;

  assign occ_ext[MAX_NESTING]  = 1'b0;
  assign mode_ext[MAX_NESTING] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < MAX_NESTING; i++) begin : g_cell
      logic occ_up;
      logic mode_up;
      if (i == 0) begin : g_head
        // A new level enters as occupied with its mode still to be decided.
        assign occ_up  = 1'b1;
        assign mode_up = 1'b0;
      end else begin : g_body
        assign occ_up  = occ_ext[i-1];
        assign mode_up = pass[i-1];
      end
      bsls_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .wr_en     ((i == 0) ? ctl.wr_en : 1'b0),
        .wr_val    ((i == 0) ? ctl.wr_val : 1'b0),
        .occ_up    (occ_up),
        .mode_up   (mode_up),
        .occ_down  (occ_ext[i+1]),
        .mode_down (mode_ext[i+1]),
        .occ       (occ_ext[i]),
        .mode      (mode_ext[i]),
        .pass_mode (pass[i])
      );
    end
  endgenerate

  assign stat.empty     = ~occ_ext[0];
  assign stat.one_level = occ_ext[0] & ~occ_ext[1];
  assign stat.full      = occ_ext[MAX_NESTING-1];
  assign stat.top_code  = mode_ext[0];

endmodule

// File: rtl/bsls_outq.sv
// Four-entry result queue taking up to two results per cycle, delivering one per cycle while out_stall is low.
// Depends on bsls_pkg for the result struct.
module bsls_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  bsls_pkg::res_t    res0,
  input  logic              push1,
  input  bsls_pkg::res_t    res1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output bsls_pkg::res_t    res_out
);
  import bsls_pkg::*;

  res_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic [1:0] wp1;
  logic [1:0] n_in;
  logic       pop;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign res_out   = mem[rp];
  assign wp1       = push0 ? (wp + 2'd1) : wp;
  assign n_in      = {1'b0, push0} + {1'b0, push1};

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wp] <= res0;
    end
    if (push1) begin
      mem[wp1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_in;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, n_in} - {2'b0, pop};
    end
  end

endmodule

// File: rtl/bsls_checker.sv
// Port-level checks for the bracket string literal scanner, bound to the top level.
// Depends on bsls_pkg for the closing bracket code and on the top level's ports.
module bsls_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       literal_done,
  input logic       unbalanced
);
  import bsls_pkg::*;

  // An error transaction carries no byte and never ends a literal.
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && unbalanced |-> out_byte == 8'h00 && !literal_done)
    else $error("error result carries data");

  // The end of a literal is always its closing bracket.
  a_done_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && literal_done |-> out_byte == CH_CLOSE && !unbalanced)
    else $error("literal end without closing bracket");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result stays on offer unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(literal_done) && $stable(unbalanced))
    else $error("stalled result changed");

endmodule

bind bracket_string_literal_scanner bsls_checker u_bsls_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .literal_done (literal_done),
  .unbalanced   (unbalanced)
);

// File: bench/bracket_string_literal_scanner_tb.sv
// Self-checking testbench for the bracket string literal scanner: a directed table of
// source bytes and shaped random literals, checked by the model or typed results.
// Depends on bsls_pkg and on the RTL top level bracket_string_literal_scanner.
module bracket_string_literal_scanner_tb;
  import bsls_pkg::*;

  // Stack depth of the instance and the bench's own model of it.
  localparam int NEST_LIMIT = 16;
  // Cycles without any accepted transaction before the run is abandoned. The slowest
  // correct run has its longest quiet spell in the receiver hold-off below, which is
  // far shorter than this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the one long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 64;
  // Counted input transactions per random phase (four phases in all).
  localparam int PHASE_ITEMS = 363;
  // Cycles to wait after the last expected result, to catch stray extra results.
  localparam int TAIL_CYCLES = 8;

  // Idling per random phase: none, sender gaps, receiver stalls, both lightly.
  localparam int SEND_GAP_PCT [4] = '{0, 58, 0, 16};
  localparam int STALL_PCT [4] = '{0, 0, 58, 16};

  // Blank characters that the package does not name.
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // How a row of the directed table is checked.
  localparam logic CHECK_MODEL = 1'b0;
  localparam logic CHECK_TYPED = 1'b1;

  localparam res_t NIL = '0;

  // One row of the directed table. Rows marked CHECK_TYPED carry their results
  // written out by hand; the others are checked against the behavioural model.
  typedef struct packed {
    logic [7:0] ch;
    logic       src_end;
    logic [4:0] reps;
    logic       typed;
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
  } dir_row_t;

  localparam dir_row_t SCRIPT [25] = '{
    // Outside a literal anything but an opening bracket is dropped.
    '{8'h41,    1'b0, 5'd1,  CHECK_TYPED, 2'd0, NIL, NIL},
    '{CH_OPEN,  1'b0, 5'd1,  CHECK_TYPED, 2'd1, '{CH_OPEN, 1'b0, 1'b0}, NIL},
    // Leading whitespace, then a newline: this level becomes a code level.
    '{CH_SPACE, 1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_TAB,   1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_NL,    1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    // A comment passes brackets and NUL raw until the newline.
    '{CH_HASH,  1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_CLOSE, 1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{8'h00,    1'b0, 5'd1,  CHECK_TYPED, 2'd1, '{8'h00, 1'b0, 1'b0}, NIL},
    '{CH_NL,    1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    // Nested level under a code level decides its own mode; a byte above 127
    // is not whitespace, so it makes the level plain.
    '{CH_OPEN,  1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_CR,    1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{8'h85,    1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_HASH,  1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    // Plain level opens a plain level; a backslash hides the closing bracket.
    '{CH_OPEN,  1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_ESC,   1'b0, 5'd1,  CHECK_TYPED, 2'd0, NIL, NIL},
    '{CH_CLOSE, 1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{8'hFF,    1'b0, 5'd1,  CHECK_TYPED, 2'd1, '{8'hFF, 1'b0, 1'b0}, NIL},
    '{CH_CLOSE, 1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_CLOSE, 1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_CLOSE, 1'b0, 5'd1,  CHECK_TYPED, 2'd1, '{CH_CLOSE, 1'b1, 1'b0}, NIL},
    // The source ends with the literal still open: byte, then error.
    '{CH_OPEN,  1'b1, 5'd1,  CHECK_TYPED, 2'd2, '{CH_OPEN, 1'b0, 1'b0},
                                                 '{8'h00, 1'b0, 1'b1}},
    // The source ends on a backslash: only the error.
    '{CH_OPEN,  1'b0, 5'd1,  CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_ESC,   1'b1, 5'd1,  CHECK_TYPED, 2'd1, '{8'h00, 1'b0, 1'b1}, NIL},
    // Fill the level stack, then one more opening bracket overflows it.
    '{CH_OPEN,  1'b0, 5'd16, CHECK_MODEL, 2'd0, NIL, NIL},
    '{CH_OPEN,  1'b0, 5'd1,  CHECK_TYPED, 2'd1, '{8'h00, 1'b0, 1'b1}, NIL}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       source_ends;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       literal_done;
  logic       unbalanced;

  bracket_string_literal_scanner #(
    .MAX_NESTING(NEST_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .source_ends (source_ends),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .literal_done(literal_done),
    .unbalanced  (unbalanced)
  );

  // Results still owed by the block, oldest first, and the ones the model has just
  // worked out for the latest accepted byte.
  res_t literal_bytes_due [$];
  res_t step_results [$];

  // The bench's own copy of the scanner state.
  bit          lvl_code [NEST_LIMIT];
  int unsigned depth;
  bit          detecting;
  bit          escaped;
  bit          commenting;

  // Stimulus shaping: the current literal is being driven towards overflow.
  bit diving;

  int mismatches;
  int quiet_cycles;
  int sender_gap_pct;
  int stall_pct;
  bit hold_req;

  always #10 clk = ~clk;

  function automatic res_t make_result(logic [7:0] d, logic dn, logic bd);
    res_t r;
    r.data = d;
    r.done = dn;
    r.bad  = bd;
    return r;
  endfunction

  // Adds one result to those of the byte being modelled.
  function automatic void emit(res_t r);
    step_results = {step_results, r};
  endfunction

  function automatic bit whitespace(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void drop_literal();
    depth      = 0;
    detecting  = 1'b0;
    escaped    = 1'b0;
    commenting = 1'b0;
  endfunction

  // Behavioural model of one source byte: updates the state copy above and leaves
  // the results this byte causes in step_results.
  task automatic scan_byte(input logic [7:0] b, input logic src_end);
    int unsigned top;
    bit code;
    bit taken;
    step_results.delete();
    if (depth == 0) begin
      if (b == CH_OPEN) begin
        lvl_code[0] = 1'b0;
        depth       = 1;
        detecting   = 1'b1;
        escaped     = 1'b0;
        commenting  = 1'b0;
        emit(make_result(b, 1'b0, 1'b0));
      end
    end else if (escaped) begin
      escaped = 1'b0;
      emit(make_result(b, 1'b0, 1'b0));
    end else if (commenting && b != CH_NL) begin
      emit(make_result(b, 1'b0, 1'b0));
    end else begin
      top        = depth - 1;
      taken      = 1'b0;
      commenting = 1'b0;
      // While the mode of the top level is still open, blanks pass and a newline
      // settles it as a code level; anything else settles it as plain and is then
      // handled below under plain rules.
      if (detecting) begin
        if (whitespace(b)) begin
          emit(make_result(b, 1'b0, 1'b0));
          if (b == CH_NL) begin
            lvl_code[top] = 1'b1;
            detecting     = 1'b0;
          end
          taken = 1'b1;
        end else begin
          lvl_code[top] = 1'b0;
          detecting     = 1'b0;
        end
      end
      if (!taken) begin
        code = lvl_code[top];
        if (b == CH_ESC) begin
          escaped = 1'b1;
        end else if (b == CH_HASH && code) begin
          emit(make_result(b, 1'b0, 1'b0));
          commenting = 1'b1;
        end else if (b == CH_OPEN) begin
          if (depth >= NEST_LIMIT) begin
            emit(make_result(8'h00, 1'b0, 1'b1));
            drop_literal();
          end else begin
            lvl_code[depth] = 1'b0;
            depth           = depth + 1;
            detecting       = code;
            emit(make_result(b, 1'b0, 1'b0));
          end
        end else if (b == CH_CLOSE) begin
          emit(make_result(b, depth == 1, 1'b0));
          depth = depth - 1;
          if (depth == 0) drop_literal();
        end else begin
          emit(make_result(b, 1'b0, 1'b0));
        end
      end
    end
    // Source text ending inside a literal appends the error result.
    if (src_end && depth > 0) begin
      emit(make_result(8'h00, 1'b0, 1'b1));
      drop_literal();
    end
  endtask

  // A byte that could appear in the body of a literal. Diving literals lean hard on
  // opening brackets so that the stack overflows now and then.
  function automatic logic [7:0] literal_token();
    int roll;
    roll = $urandom_range(99);
    if (diving) begin
      if (roll < 55) return CH_OPEN;
      if (roll < 62) return CH_NL;
      return 8'($urandom_range(255));
    end
    if (roll < 14) return CH_OPEN;
    if (roll < 34) return CH_CLOSE;
    if (roll < 41) return CH_ESC;
    if (roll < 49) return CH_HASH;
    if (roll < 57) return CH_NL;
    if (roll < 62) return CH_SPACE;
    return 8'($urandom_range(255));
  endfunction

  // Picks the next source byte from the model's current state, so that most of the
  // stream forms real literals with random content and the rest is noise.
  task automatic choose_source_byte(output logic [7:0] b, output logic src_end);
    int roll;
    roll    = $urandom_range(99);
    src_end = 1'b0;
    if (depth == 0) begin
      b = (roll < 60) ? CH_OPEN : 8'($urandom_range(255));
      if (b == CH_OPEN) diving = ($urandom_range(9) == 0);
      src_end = ($urandom_range(99) < 3);
    end else if (commenting) begin
      b = (roll < 15) ? CH_NL : 8'($urandom_range(255));
    end else if (escaped) begin
      b = (roll < 50) ? literal_token() : 8'($urandom_range(255));
    end else if (detecting) begin
      if (roll < 30) begin
        b = CH_NL;
      end else if (roll < 50) begin
        case ($urandom_range(4))
          0:       b = CH_SPACE;
          1:       b = CH_TAB;
          2:       b = CH_VT;
          3:       b = CH_FF;
          default: b = CH_CR;
        endcase
      end else begin
        b = literal_token();
      end
    end else begin
      b = literal_token();
    end
    // Now and then the source text stops in the middle of a literal, and a little
    // more often straight after a backslash.
    if (depth > 0 && $urandom_range(149) == 0) src_end = 1'b1;
    if (depth > 0 && !escaped && !commenting && b == CH_ESC && $urandom_range(29) == 0)
      src_end = 1'b1;
  endtask

  // Offers one byte from a falling edge, with random gaps beforehand, and returns at
  // the rising edge where the transaction is accepted, with the model already run.
  task automatic offer_byte(input logic [7:0] b, input logic src_end);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    source_ends <= src_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b, src_end);
  endtask

  // Lowers valid and waits until every result owed has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (literal_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %0s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Output side: every accepted result transaction is held against the oldest one
  // owed, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (literal_bytes_due.size() == 0) begin
        report_mismatch("unexpected result, out_byte", out_byte, 0);
      end else begin
        if (out_byte !== literal_bytes_due[0].data)
          report_mismatch("out_byte", out_byte, literal_bytes_due[0].data);
        if (literal_done !== literal_bytes_due[0].done)
          report_mismatch("literal_done", literal_done, literal_bytes_due[0].done);
        if (unbalanced !== literal_bytes_due[0].bad)
          report_mismatch("unbalanced", unbalanced, literal_bytes_due[0].bad);
        void'(literal_bytes_due.pop_front());
      end
    end
  end

  // Receiver: random stalls at the phase's rate, and on request one long hold-off,
  // counted here, during which the sender keeps offering so that the result queue
  // fills and the block stalls its input.
  initial begin
    bit hold_used;
    hold_used = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        out_stall <= 1'b1;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("bracket_string_literal_scanner verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, then four random phases.
  initial begin
    dir_row_t   row;
    logic [7:0] b;
    logic       src_end;
    int         counted;

    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    source_ends    = 1'b0;
    hold_req       = 1'b0;
    sender_gap_pct = 0;
    stall_pct      = 0;
    diving         = 1'b0;
    foreach (lvl_code[k]) lvl_code[k] = 1'b0;
    drop_literal();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. The model is run on every row so that its state follows the
    // block; where a row has its results written out, those are what is checked.
    foreach (SCRIPT[k]) begin
      row = SCRIPT[k];
      repeat (row.reps) begin
        offer_byte(row.ch, row.src_end);
        if (row.typed == CHECK_TYPED) begin
          if (row.n_res > 0) literal_bytes_due = {literal_bytes_due, row.r0};
          if (row.n_res > 1) literal_bytes_due = {literal_bytes_due, row.r1};
        end else begin
          literal_bytes_due = {literal_bytes_due, step_results};
        end
      end
    end
    drain_results();

    // Random phases, each run until its share of bytes that touch a literal has
    // gone in, then drained so that every phase starts from a clean queue.
    for (int p = 0; p < 4; p++) begin
      sender_gap_pct = SEND_GAP_PCT[p];
      stall_pct      = STALL_PCT[p];
      counted        = 0;
      while (counted < PHASE_ITEMS) begin
        if (p == 0 && counted == 100) hold_req = 1'b1;
        // At one count mid-phase the sender pauses until the block has caught up.
        if (p == 2 && counted == 150) drain_results();
        choose_source_byte(b, src_end);
        if (depth != 0 || b == CH_OPEN) counted++;
        offer_byte(b, src_end);
        literal_bytes_due = {literal_bytes_due, step_results};
      end
      drain_results();
    end

    // Quiet tail: anything arriving now is an extra result and gets flagged.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("bracket_string_literal_scanner verification clean");
    else
      $display("bracket_string_literal_scanner verification failed");
    $finish;
  end

endmodule
